/* src/positional_list_store_core_assert.svh */
// assertion macros for the positional list store checker
// depends on a clk and an active-low arst_n in the scope of use
`ifndef POSITIONAL_LIST_STORE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_CORE_ASSERT_SVH

// same-cycle implication
`define PLSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plsc check failed");

// next-cycle implication
`define PLSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plsc check failed");

`endif

/* src/plsc_pkg.sv */
// shared types and codes for the positional list store
// no dependencies
package plsc_pkg;

	localparam int MAX_DEPTH = 64;
	localparam int CNT_W = $clog2(MAX_DEPTH + 1);
	localparam int DEF_DEPTH = 16;
	localparam int VAL_W = 32;
	localparam int POS_W = 8;
	localparam int OCC_W = 5;

	typedef enum logic [2:0] {
		CMD_INS_FIRST = 3'd0,
		CMD_INS_LAST  = 3'd1,
		CMD_INS_AT    = 3'd2,
		CMD_DEL_FIRST = 3'd3,
		CMD_DEL_LAST  = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_DISPLAY   = 3'd6,
		CMD_COUNT     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_INS,
		ACT_DEL,
		ACT_ROT
	} act_t;

	typedef enum logic {
		ST_IDLE,
		ST_SHOW
	} state_t;

	typedef struct packed {
		logic [2:0]             command;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] element;
		logic [OCC_W-1:0]        occupancy;
		logic [1:0]              status;
		logic                    last;
	} rsp_t;

	typedef struct packed {
		act_t                    act;
		logic [CNT_W-1:0]        idx;
		logic [CNT_W-1:0]        held;
		logic signed [VAL_W-1:0] value;
	} ctrl_t;

endpackage

/* src/plsc_cell.sv */
// one slot of the list chain: holds a value and shifts with its neighbors
// depends on plsc_pkg
module plsc_cell #(
	parameter int IDX = 0
) (
	input  logic                             clk,
	input  plsc_pkg::ctrl_t                  ctl,
	input  logic signed [plsc_pkg::VAL_W-1:0] left,
	input  logic signed [plsc_pkg::VAL_W-1:0] right,
	input  logic signed [plsc_pkg::VAL_W-1:0] head,
	output logic signed [plsc_pkg::VAL_W-1:0] q
);
	import plsc_pkg::*;

	localparam logic [CNT_W-1:0] ME   = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] ME_1 = CNT_W'(IDX + 1);

	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] val_d;

	always_comb begin
		val_d = val_q;
		case (ctl.act)
			ACT_INS: begin
				if (ME == ctl.idx) val_d = ctl.value;
				else if (ME > ctl.idx) val_d = left;
			end
			ACT_DEL: begin
				if (ME >= ctl.idx) val_d = right;
			end
			ACT_ROT: begin
				if (ME_1 == ctl.held) val_d = head;
				else if (ME_1 < ctl.held) val_d = right;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign q = val_q;

endmodule

/* src/positional_list_store_core.sv */
// positional list store: command decode, occupancy and a chain of value cells
// depends on plsc_pkg and plsc_cell
//
// channel  | ports                 | handshake
// command  | start, req, busy      | taken when start && !busy
// result   | valid, rsp            | one cycle per result, no back-pressure
//
// insert, delete and count results show in the cycle after the command is taken
// display: the cell chain rotates one place a cycle and
// the head cell streams out, leaving the list as it was
// display of an empty list answers at once, like the other commands
// reset clears occupancy and control; cell contents stay undefined
// results can never be held off, so the block never stalls on the output
module positional_list_store_core #(
	parameter int DEPTH = plsc_pkg::DEF_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  plsc_pkg::cmd_t  req,
	output logic            busy,
	output logic            valid,
	output plsc_pkg::rsp_t  rsp
);
	import plsc_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = POS_W + 1;

	state_t state_q, state_d;
	logic [CW-1:0] held_q, held_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          valid_q, valid_d;
	rsp_t          rsp_q, rsp_d;
	ctrl_t         ctl;

	logic signed [VAL_W-1:0] cell_q [DEPTH];

	logic acc, full, empty, last_elem;
	logic [XW-1:0] pos_x, held_x;
	logic pos0;

	assign acc       = start && (state_q == ST_IDLE);
	assign full      = (held_q == CW'(DEPTH));
	assign empty     = (held_q == '0);
	assign pos_x     = {1'b0, req.position};
	assign held_x    = XW'(held_q);
	assign pos0      = (req.position == '0);
	assign last_elem = ((cnt_q + CW'(1)) == held_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc && req.command == CMD_DISPLAY && !empty) state_d = ST_SHOW;
			ST_SHOW: if (last_elem) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control and results
	always_comb begin
		status_t st;
		st          = STAT_OK;
		ctl.act     = ACT_HOLD;
		ctl.idx     = '0;
		ctl.held    = CNT_W'(held_q);
		ctl.value   = req.value;
		held_d      = held_q;
		cnt_d       = cnt_q;
		valid_d     = 1'b0;
		rsp_d       = rsp_q;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (acc) begin
					valid_d = 1'b1;
					unique case (req.command)
						CMD_INS_FIRST: begin
							if (full) st = STAT_FULL;
							else begin
								ctl.act = ACT_INS;
								ctl.idx = '0;
							end
						end
						CMD_INS_LAST: begin
							if (full) st = STAT_FULL;
							else begin
								ctl.act = ACT_INS;
								ctl.idx = CNT_W'(held_q);
							end
						end
						CMD_INS_AT: begin
							if (pos0 || pos_x > held_x + XW'(1)) st = STAT_BADPOS;
							else if (full) st = STAT_FULL;
							else begin
								ctl.act = ACT_INS;
								ctl.idx = CNT_W'(req.position - POS_W'(1));
							end
						end
						CMD_DEL_FIRST: begin
							if (empty) st = STAT_EMPTY;
							else begin
								ctl.act = ACT_DEL;
								ctl.idx = '0;
							end
						end
						CMD_DEL_LAST: begin
							if (empty) st = STAT_EMPTY;
							else begin
								ctl.act = ACT_DEL;
								ctl.idx = CNT_W'(held_q - CW'(1));
							end
						end
						CMD_DEL_AT: begin
							if (empty) st = STAT_EMPTY;
							else if (pos0 || pos_x > held_x) st = STAT_BADPOS;
							else begin
								ctl.act = ACT_DEL;
								ctl.idx = CNT_W'(req.position - POS_W'(1));
							end
						end
						CMD_DISPLAY: begin
							if (empty) st = STAT_EMPTY;
							else valid_d = 1'b0;
						end
						CMD_COUNT: st = STAT_OK;
						default: st = STAT_OK;
					endcase
					if (ctl.act == ACT_INS) held_d = held_q + CW'(1);
					else if (ctl.act == ACT_DEL) held_d = held_q - CW'(1);
					rsp_d.element   = '0;
					rsp_d.occupancy = OCC_W'(held_d);
					rsp_d.status    = st;
					rsp_d.last      = 1'b1;
				end
			end
			ST_SHOW: begin
				ctl.act         = ACT_ROT;
				cnt_d           = cnt_q + CW'(1);
				valid_d         = 1'b1;
				rsp_d.element   = cell_q[0];
				rsp_d.occupancy = OCC_W'(held_q);
				rsp_d.status    = STAT_OK;
				rsp_d.last      = last_elem;
			end
			default: begin
				ctl.act = ACT_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			cnt_q   <= cnt_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] lft, rgt;
		if (i == 0) begin : g_first
			assign lft = req.value;
		end else begin : g_mid_l
			assign lft = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign rgt = cell_q[i];
		end else begin : g_mid_r
			assign rgt = cell_q[i+1];
		end
		plsc_cell #(.IDX(i)) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (lft),
			.right (rgt),
			.head  (cell_q[0]),
			.q     (cell_q[i])
		);
	end

	assign busy  = (state_q == ST_SHOW);
	assign valid = valid_q;
	assign rsp   = rsp_q;

endmodule

/* src/plsc_checker.sv */
// port-level checks for the positional list store, bound to the top level
// depends on plsc_pkg and positional_list_store_core_assert.svh
`include "positional_list_store_core_assert.svh"

module plsc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           valid,
	input plsc_pkg::rsp_t rsp
);
	import plsc_pkg::*;

	// display results come one a cycle until the last one
	`PLSC_ASSERT_NEXT(a_stream_cont, valid && !rsp.last, valid)
	// a display still in progress keeps the command side closed
	`PLSC_ASSERT_NOW(a_stream_busy, valid && !rsp.last, busy)
	// refused results carry no element
	`PLSC_ASSERT_NOW(a_err_zero, valid && rsp.status != STAT_OK, rsp.element == '0)
	// an empty status always reports an empty list
	`PLSC_ASSERT_NOW(a_empty_occ, valid && rsp.status == STAT_EMPTY, rsp.occupancy == '0)
	// busy only begins after a command was taken
	`PLSC_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start))

endmodule

bind positional_list_store_core plsc_checker u_plsc_checker (.*);

/* tb/testbench.sv */
// testbench for positional_list_store_core: directed table, then biased random commands
// checks every result against an in-bench list model; depends on plsc_pkg and the core
`timescale 1ns / 1ps

module testbench;
	import plsc_pkg::*;

	localparam int DEPTH = DEF_DEPTH;
	localparam int RANDOM_ITEMS = 440;

	typedef struct {
		cmd_t item;
		int   reps;
		bit   fixed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	cmd_t req;
	logic busy;
	logic valid;
	rsp_t rsp;

	// list model state
	logic signed [VAL_W-1:0] list_vals [DEPTH];
	int unsigned             list_len;

	rsp_t     pending_rsp_q [$];
	dir_row_t dir_rows [$];

	int  failures;
	int  items_sent;
	int  results_checked;
	int  display_streams;
	int  refusals;
	int  full_hits;
	bit  quiet;

	positional_list_store_core #(.DEPTH(DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.valid  (valid),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	task automatic note_failure(input string what);
		failures++;
		if (failures <= 10)
			$display("mismatch: %s", what);
	endtask

	function automatic rsp_t make_rsp(input logic signed [VAL_W-1:0] elem, input int unsigned occ,
			input status_t st, input bit fin);
		rsp_t r;
		r.element = elem;
		r.occupancy = OCC_W'(occ);
		r.status = st;
		r.last = fin;
		return r;
	endfunction

	task automatic place_value(input int unsigned idx, input logic signed [VAL_W-1:0] v);
		int unsigned k;
		for (k = list_len; k > idx; k--)
			list_vals[k] = list_vals[k-1];
		list_vals[idx] = v;
		list_len++;
	endtask

	task automatic drop_value(input int unsigned idx);
		int unsigned k;
		for (k = idx; k + 1 < list_len; k++)
			list_vals[k] = list_vals[k+1];
		list_len--;
	endtask

	// apply one command to the list model and queue the results it gives
	task automatic predict_list_results(input cmd_t item);
		op_t         op;
		status_t     st;
		int unsigned p;
		int unsigned k;
		op = op_t'(item.command);
		p = item.position;
		st = STAT_OK;
		case (op)
			CMD_INS_FIRST: begin
				if (list_len >= DEPTH) st = STAT_FULL;
				else place_value(0, item.value);
			end
			CMD_INS_LAST: begin
				if (list_len >= DEPTH) st = STAT_FULL;
				else place_value(list_len, item.value);
			end
			CMD_INS_AT: begin
				if (p < 1 || p > list_len + 1) st = STAT_BADPOS;
				else if (list_len >= DEPTH) st = STAT_FULL;
				else place_value(p - 1, item.value);
			end
			CMD_DEL_FIRST: begin
				if (list_len == 0) st = STAT_EMPTY;
				else drop_value(0);
			end
			CMD_DEL_LAST: begin
				if (list_len == 0) st = STAT_EMPTY;
				else drop_value(list_len - 1);
			end
			CMD_DEL_AT: begin
				if (list_len == 0) st = STAT_EMPTY;
				else if (p < 1 || p > list_len) st = STAT_BADPOS;
				else drop_value(p - 1);
			end
			CMD_DISPLAY: begin
				display_streams++;
				if (list_len == 0) begin
					pending_rsp_q.push_back(make_rsp('0, 0, STAT_EMPTY, 1'b1));
				end else begin
					for (k = 0; k < list_len; k++)
						pending_rsp_q.push_back(make_rsp(list_vals[k], list_len, STAT_OK,
							k + 1 == list_len));
				end
				return;
			end
			default: ;
		endcase
		if (st != STAT_OK) refusals++;
		if (st == STAT_FULL) full_hits++;
		pending_rsp_q.push_back(make_rsp('0, list_len, st, 1'b1));
	endtask

	function automatic void add_row(input op_t op, input logic signed [VAL_W-1:0] v,
			input int unsigned pos, input int reps, input bit fixed,
			input int unsigned occ, input status_t st);
		dir_row_t row;
		row.item.command = op;
		row.item.value = v;
		row.item.position = POS_W'(pos);
		row.reps = reps;
		row.fixed = fixed;
		row.want = make_rsp('0, occ, st, 1'b1);
		dir_rows.push_back(row);
	endfunction

	function automatic cmd_t draw_item(input int bias);
		cmd_t item;
		int   r;
		int   ins_top;
		r = $urandom_range(0, 99);
		ins_top = (bias == 0) ? 65 : (bias == 1) ? 25 : 40;
		if (r < ins_top)
			item.command = 3'($urandom_range(CMD_INS_FIRST, CMD_INS_AT));
		else if (r < 80)
			item.command = 3'($urandom_range(CMD_DEL_FIRST, CMD_DEL_AT));
		else if (r < 92)
			item.command = CMD_DISPLAY;
		else
			item.command = CMD_COUNT;
		case ($urandom_range(0, 7))
			0: item.value = 32'sh8000_0000;
			1: item.value = 32'sh7fff_ffff;
			2: item.value = '0;
			3: item.value = -32'sd1;
			default: item.value = $urandom;
		endcase
		if ($urandom_range(0, 4) == 0)
			item.position = POS_W'($urandom_range(0, 255));
		else
			item.position = POS_W'($urandom_range(0, list_len + 2));
		return item;
	endfunction

	task automatic hold_off();
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_item(input cmd_t item, input bit fixed, input rsp_t want);
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		items_sent++;
		predict_list_results(item);
		if (fixed) begin
			void'(pending_rsp_q.pop_back());
			pending_rsp_q.push_back(want);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_rsp_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : watch_results
		rsp_t want;
		if (arst_n && valid) begin
			if (pending_rsp_q.size() == 0) begin
				note_failure($sformatf("unexpected result elem %0d occ %0d status %0d last %0d",
					rsp.element, rsp.occupancy, rsp.status, rsp.last));
			end else begin
				want = pending_rsp_q.pop_front();
				results_checked++;
				if (rsp.element !== want.element)
					note_failure($sformatf("element expected %0d got %0d", want.element,
						rsp.element));
				if (rsp.occupancy !== want.occupancy)
					note_failure($sformatf("occupancy expected %0d got %0d", want.occupancy,
						rsp.occupancy));
				if (rsp.status !== want.status)
					note_failure($sformatf("status expected %0d got %0d", want.status,
						rsp.status));
				if (rsp.last !== want.last)
					note_failure($sformatf("last expected %0d got %0d", want.last, rsp.last));
			end
		end
	end

	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int   n;
		int   bias;
		int   waited;
		rsp_t none;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		list_len = 0;
		none = '0;
		quiet = 1'b0;

		// empty list and bad positions
		add_row(CMD_DISPLAY,   '0, 0, 1, 1, 0, STAT_EMPTY);
		add_row(CMD_COUNT,     '0, 0, 1, 1, 0, STAT_OK);
		add_row(CMD_DEL_FIRST, '0, 0, 1, 1, 0, STAT_EMPTY);
		add_row(CMD_DEL_LAST,  '0, 0, 1, 1, 0, STAT_EMPTY);
		add_row(CMD_DEL_AT,    '0, 0, 1, 1, 0, STAT_EMPTY);
		add_row(CMD_INS_AT,    '0, 0, 1, 1, 0, STAT_BADPOS);
		add_row(CMD_INS_AT,    '0, 2, 1, 1, 0, STAT_BADPOS);
		add_row(CMD_INS_AT,    32'sh8000_0000, 1, 1, 1, 1, STAT_OK);
		add_row(CMD_DISPLAY,   '0, 0, 1, 0, 0, STAT_OK);
		// only element removed
		add_row(CMD_DEL_AT,    '0, 1, 1, 1, 0, STAT_OK);
		add_row(CMD_INS_FIRST, 32'sh7fff_ffff, 0, 1, 1, 1, STAT_OK);
		add_row(CMD_INS_LAST,  -32'sd1, 255, 1, 1, 2, STAT_OK);
		add_row(CMD_INS_AT,    '0, 3, 1, 0, 0, STAT_OK);
		add_row(CMD_DEL_AT,    '0, 4, 1, 1, 3, STAT_BADPOS);
		// delete at the last position
		add_row(CMD_DEL_AT,    '0, 3, 1, 0, 0, STAT_OK);
		add_row(CMD_DISPLAY,   '0, 0, 1, 0, 0, STAT_OK);
		add_row(CMD_DEL_LAST,  '0, 0, 1, 0, 0, STAT_OK);
		add_row(CMD_DEL_FIRST, '0, 0, 1, 1, 0, STAT_OK);
		// fill to capacity, then refusals on a full store
		add_row(CMD_INS_LAST,  32'sh5a5a_a5a5, 0, DEPTH, 0, 0, STAT_OK);
		add_row(CMD_INS_FIRST, '0, 0, 1, 1, DEPTH, STAT_FULL);
		add_row(CMD_INS_AT,    '0, DEPTH + 1, 1, 1, DEPTH, STAT_FULL);
		add_row(CMD_INS_AT,    '0, DEPTH + 2, 1, 1, DEPTH, STAT_BADPOS);
		add_row(CMD_DEL_AT,    '0, 255, 1, 1, DEPTH, STAT_BADPOS);
		add_row(CMD_DISPLAY,   '0, 0, 1, 0, 0, STAT_OK);
		add_row(CMD_DEL_AT,    '0, DEPTH, 1, 0, 0, STAT_OK);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			repeat (dir_rows[i].reps) begin
				hold_off();
				send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
			end
		end
		wait_drained();

		bias = 2;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) bias = $urandom_range(0, 2);
			if (n % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 2) wait_drained();
			hold_off();
			send_item(draw_item(bias), 1'b0, none);
		end
		start <= 1'b0;

		waited = 0;
		while (pending_rsp_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (pending_rsp_q.size() != 0)
			note_failure($sformatf("%0d expected results never arrived", pending_rsp_q.size()));

		$display("sent %0d commands, checked %0d results", items_sent, results_checked);
		$display("%0d display streams, %0d refusals (%0d on a full store), %0d failures",
			display_streams, refusals, full_hits, failures);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/plsc_pkg.sv
src/plsc_cell.sv
src/positional_list_store_core.sv
src/plsc_checker.sv
tb/testbench.sv
